// ----- rtl/bdq_pkg.sv -----
// ----------------------------------------------------------------------------
// bdq_pkg
// Types, constants and ring pointer helpers of the bounded deque.
// ----------------------------------------------------------------------------
`default_nettype none

package bdq_pkg;

  localparam int MAX_DEPTH = 1024;
  localparam int PTR_W     = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int COUNT_W   = $clog2(MAX_DEPTH + 1);
  localparam int CAP_W     = 11;
  localparam int DATA_W    = 32;
  localparam int CMP_W     = (COUNT_W > CAP_W) ? COUNT_W : CAP_W;

  localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

  localparam logic [2:0] REQ_INS_FRONT = 3'd0;
  localparam logic [2:0] REQ_INS_REAR  = 3'd1;
  localparam logic [2:0] REQ_DEL_FRONT = 3'd2;
  localparam logic [2:0] REQ_DEL_REAR  = 3'd3;
  localparam logic [2:0] REQ_PEEK      = 3'd4;

  typedef struct packed {
    logic [2:0]               req_type;
    logic signed [DATA_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic                     ok;
    logic signed [DATA_W-1:0] front_value;
    logic signed [DATA_W-1:0] rear_value;
    logic                     empty_res;
    logic                     full_res;
  } res_t;

  typedef struct packed {
    logic exec;
    logic resp;
  } ctrl_cmd_t;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(MAX_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
    ptr_dec = (p == '0) ? PTR_W'(MAX_DEPTH - 1) : p - PTR_W'(1);
  endfunction

endpackage

`default_nettype wire

// ----- rtl/bounded_double_ended_queue.sv -----
// ----------------------------------------------------------------------------
// bounded_double_ended_queue
// Ring-buffer deque with configurable capacity.
//
// Requests enter on req_i, accepted at a clock edge with start high and
// busy low. Each request gives one result on res_o, marked by done_o for
// exactly one cycle, the cycle after acceptance; the receiver cannot stall.
// busy is high during that result cycle, so a new item is accepted only
// after the result has been given. The result cycle exists for the
// registered read port of the entry RAM, which supplies the new front or
// rear entry after a delete; inserts update the cached ends directly.
// The capacity register is written over cfg_valid_i/cfg_data_i (cfg_ready_o
// always high); the user must write it only while no item is in flight,
// which the block does not enforce; capacity above the store size acts as
// the store size. Reset empties the deque and sets capacity to 1024; no
// clearing pass is needed, as unoccupied entries never reach res_o.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_double_ended_queue (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start,
  output logic                           busy,
  input  wire bdq_pkg::req_t             req_i,
  output logic                           done_o,
  output bdq_pkg::res_t                  res_o,
  input  wire logic                      cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire logic [bdq_pkg::CAP_W-1:0] cfg_data_i
);

  bdq_pkg::ctrl_cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  bdq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .cmd_o  (cmd)
  );

  bdq_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .req_i       (req_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .res_o       (res_o)
  );

endmodule

`default_nettype wire

// ----- rtl/bdq_ram.sv -----
// ----------------------------------------------------------------------------
// bdq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                       wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/bdq_ctrl.sv -----
// ----------------------------------------------------------------------------
// bdq_ctrl
// Request sequencer: accept, then one response cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bdq_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  output logic                    done_o,
  output bdq_pkg::ctrl_cmd_t      cmd_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RESP = 1'b1;

  logic state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start) state_d = ST_RESP;
      end
      ST_RESP: begin
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy       = (state_q == ST_RESP);
  assign done_o     = (state_q == ST_RESP);
  assign cmd_o.exec = start && (state_q == ST_IDLE);
  assign cmd_o.resp = (state_q == ST_RESP);

  a_resp_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("response held beyond one cycle");

  a_done_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.exec |=> done_o) else $error("accepted item gave no response");

  a_no_exec_in_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.exec && cmd_o.resp)) else $error("accept during response");

endmodule

`default_nettype wire

// ----- rtl/bdq_dp.sv -----
// ----------------------------------------------------------------------------
// bdq_dp
// Deque datapath: ring pointers, occupancy, end caches and entry RAM.
// ----------------------------------------------------------------------------
`default_nettype none

module bdq_dp (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire bdq_pkg::ctrl_cmd_t                 cmd_i,
  input  wire bdq_pkg::req_t                      req_i,
  input  wire logic                               cfg_valid_i,
  input  wire logic [bdq_pkg::CAP_W-1:0]          cfg_data_i,
  output bdq_pkg::res_t                           res_o
);

  logic [bdq_pkg::PTR_W-1:0]   head_q, head_d, tail_q, tail_d;
  logic [bdq_pkg::COUNT_W-1:0] occ_q, occ_d;
  logic [bdq_pkg::CAP_W-1:0]   cap_q;
  logic [bdq_pkg::DATA_W-1:0]  front_q, rear_q;
  logic                        ok_q, ok_d, self_q, self_d, selr_q, selr_d;

  logic                        we;
  logic [bdq_pkg::PTR_W-1:0]   waddr, raddr;
  logic [bdq_pkg::DATA_W-1:0]  rdata;

  logic [bdq_pkg::CMP_W-1:0]   cap_eff, occ_ext;
  logic                        full_now, empty_now;

  assign cap_eff = (bdq_pkg::CMP_W'(cap_q) > bdq_pkg::CMP_W'(bdq_pkg::MAX_DEPTH))
                 ? bdq_pkg::CMP_W'(bdq_pkg::MAX_DEPTH) : bdq_pkg::CMP_W'(cap_q);
  assign occ_ext   = bdq_pkg::CMP_W'(occ_q);
  assign full_now  = (occ_ext >= cap_eff);
  assign empty_now = (occ_q == '0);

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    occ_d  = occ_q;
    ok_d   = 1'b1;
    self_d = 1'b0;
    selr_d = 1'b0;
    we     = 1'b0;
    waddr  = tail_q;
    raddr  = bdq_pkg::ptr_inc(head_q);
    case (req_i.req_type)
      bdq_pkg::REQ_INS_FRONT: begin
        if (full_now) begin
          ok_d = 1'b0;
        end else begin
          head_d = bdq_pkg::ptr_dec(head_q);
          waddr  = bdq_pkg::ptr_dec(head_q);
          we     = cmd_i.exec;
          occ_d  = occ_q + bdq_pkg::COUNT_W'(1);
        end
      end
      bdq_pkg::REQ_INS_REAR: begin
        if (full_now) begin
          ok_d = 1'b0;
        end else begin
          tail_d = bdq_pkg::ptr_inc(tail_q);
          we     = cmd_i.exec;
          occ_d  = occ_q + bdq_pkg::COUNT_W'(1);
        end
      end
      bdq_pkg::REQ_DEL_FRONT: begin
        if (empty_now) begin
          ok_d = 1'b0;
        end else begin
          head_d = bdq_pkg::ptr_inc(head_q);
          occ_d  = occ_q - bdq_pkg::COUNT_W'(1);
          self_d = 1'b1;
        end
      end
      bdq_pkg::REQ_DEL_REAR: begin
        if (empty_now) begin
          ok_d = 1'b0;
        end else begin
          tail_d = bdq_pkg::ptr_dec(tail_q);
          raddr  = bdq_pkg::ptr_dec(bdq_pkg::ptr_dec(tail_q));
          occ_d  = occ_q - bdq_pkg::COUNT_W'(1);
          selr_d = 1'b1;
        end
      end
      default: ok_d = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      occ_q  <= '0;
      cap_q  <= bdq_pkg::CAP_RESET;
      self_q <= 1'b0;
      selr_q <= 1'b0;
    end else begin
      if (cfg_valid_i) cap_q <= cfg_data_i;
      if (cmd_i.exec) begin
        head_q <= head_d;
        tail_q <= tail_d;
        occ_q  <= occ_d;
        self_q <= self_d;
        selr_q <= selr_d;
      end else if (cmd_i.resp) begin
        self_q <= 1'b0;
        selr_q <= 1'b0;
      end
    end
  end

  // end caches: inserts load directly, deletes load from the RAM read
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      ok_q <= ok_d;
      if (we) begin
        if (req_i.req_type == bdq_pkg::REQ_INS_FRONT || empty_now) front_q <= req_i.value;
        if (req_i.req_type == bdq_pkg::REQ_INS_REAR || empty_now) rear_q <= req_i.value;
      end
    end else if (cmd_i.resp) begin
      if (self_q) front_q <= rdata;
      if (selr_q) rear_q <= rdata;
    end
  end

  bdq_ram #(
    .WIDTH (bdq_pkg::DATA_W),
    .DEPTH (bdq_pkg::MAX_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (req_i.value),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign res_o.ok          = ok_q;
  assign res_o.front_value = empty_now ? '1 : (self_q ? rdata : front_q);
  assign res_o.rear_value  = empty_now ? '1 : (selr_q ? rdata : rear_q);
  assign res_o.empty_res   = empty_now;
  assign res_o.full_res    = full_now;

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_ext <= bdq_pkg::CMP_W'(bdq_pkg::MAX_DEPTH)) else $error("occupancy overflow");

  a_one_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({self_q, selr_q})) else $error("both ends selected from RAM");

  a_refused_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec && !ok_d |=> $stable(occ_q) && $stable(head_q) && $stable(tail_q))
    else $error("refused request changed state");

  a_ins_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec && we |=> occ_q == $past(occ_q) + bdq_pkg::COUNT_W'(1))
    else $error("insert did not count up");

endmodule

`default_nettype wire
